// ===== design/ordered_pair_set_toggle_assert.svh =====
// Assertion macros for the file that checks the pair list.
// Every macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ORDERED_PAIR_SET_TOGGLE_ASSERT_SVH
`define ORDERED_PAIR_SET_TOGGLE_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define OPST_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("opst: invariant does not hold");

// When the antecedent holds, the consequent must hold in the same cycle.
`define OPST_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("opst: implication does not hold");

// When the antecedent holds, the consequent must hold in the following cycle.
`define OPST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("opst: next-cycle check does not hold");

`endif

// ===== design/opst_pkg.sv =====
package opst_pkg;

  // Field widths of one request and one response.
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned KEY_W       = 16;
  localparam int unsigned PAIR_W      = 2 * KEY_W;
  localparam int unsigned OUT_CNT_W   = 5;

  // Default list capacity.
  localparam int unsigned DEFAULT_MAX_ENTRIES = 16;

  // Request actions.
  typedef enum logic [ACTION_W-1:0] {
    ACT_QUERY  = 2'd0,
    ACT_TOGGLE = 2'd1,
    ACT_ADD    = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // Controller states.
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // Latch the request and compare it against all entries.
    logic commit;   // Update the list and load the response register.
  } ctrl_cmd_t;

endpackage

// ===== design/opst_req_if.sv =====
interface opst_req_if;

  logic                               valid;
  logic                               ready;
  logic [opst_pkg::ACTION_W-1:0]      action;
  logic [opst_pkg::KEY_W-1:0]         first_key;
  logic [opst_pkg::KEY_W-1:0]         second_key;

  modport source (output valid, action, first_key, second_key, input ready);
  modport sink   (input valid, action, first_key, second_key, output ready);

endinterface

// ===== design/opst_rsp_if.sv =====
interface opst_rsp_if;

  logic                               valid;
  logic                               ready;
  logic                               is_present;
  logic                               list_changed;
  logic                               rejected_full;
  logic [opst_pkg::OUT_CNT_W-1:0]     entry_count;

  modport source (output valid, is_present, list_changed, rejected_full, entry_count,
                  input ready);
  modport sink   (input valid, is_present, list_changed, rejected_full, entry_count,
                  output ready);

endinterface

// ===== design/ordered_pair_set_toggle.sv =====
// Ordered pair set with toggle, add, query and clear actions.
// Requests arrive on req_i (action, first_key, second_key); each request
// produces exactly one response on rsp_o (is_present, list_changed,
// rejected_full, entry_count). Both channels use valid/ready and a request
// moves when valid and ready are high at a rising clock edge.
// The list holds up to MAX_ENTRIES distinct pairs in insertion order.
// A request is compared against all live entries in the cycle it is
// accepted, and the list is updated in state S_APPLY, once the response
// register is free, while that register is loaded. rsp_o.valid rises
// together with the loaded response, and the block takes no new request
// until that update is done. The pace is set by the compare state followed
// by the update state on the shared entry lanes.
// When the receiver stalls, one finished response waits in the output
// register while the next request is still accepted and compared; its
// update waits until the output register is free, and no further request
// is accepted meanwhile.
// Reset clears the live count, so the list is empty; entry contents are
// not cleared and are never compared before they are rewritten.
module ordered_pair_set_toggle #(
  parameter int unsigned MAX_ENTRIES = opst_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  opst_req_if.sink          req_i,
  opst_rsp_if.source        rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  opst_pkg::ctrl_cmd_t cmd;
  logic [CNT_W-1:0]    count;

  // Sequencer.
  opst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // Entry lanes and response register.
  opst_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (req_i.action),
    .first_key_i     (req_i.first_key),
    .second_key_i    (req_i.second_key),
    .is_present_o    (rsp_o.is_present),
    .list_changed_o  (rsp_o.list_changed),
    .rejected_full_o (rsp_o.rejected_full),
    .entry_count_o   (rsp_o.entry_count),
    .count_o         (count)
  );

  // Design checks.
`include "ordered_pair_set_toggle_assert.svh"

  `OPST_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(MAX_ENTRIES))
  `OPST_ASSERT_NEXT(a_one_in_flight, req_i.valid && req_i.ready, !req_i.ready)
  `OPST_ASSERT_IMPLY(a_reject_excl, rsp_o.valid, !(rsp_o.list_changed && rsp_o.rejected_full))
  `OPST_ASSERT_IMPLY(a_reject_full, rsp_o.valid && rsp_o.rejected_full, count == CNT_W'(MAX_ENTRIES))

endmodule

// ===== design/opst_ctrl.sv =====
module opst_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   req_valid_i,
  output logic                   req_ready_o,
  output logic                   rsp_valid_o,
  input  logic                   rsp_ready_i,
  output opst_pkg::ctrl_cmd_t    cmd_o
);

  opst_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // The response register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || rsp_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      opst_pkg::S_IDLE: begin
        if (req_valid_i) state_d = opst_pkg::S_APPLY;
      end
      opst_pkg::S_APPLY: begin
        if (out_free) state_d = opst_pkg::S_IDLE;
      end
      default: state_d = opst_pkg::S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      opst_pkg::S_IDLE: begin
        req_ready_o   = 1'b1;
        cmd_o.capture = req_valid_i;
      end
      opst_pkg::S_APPLY: begin
        cmd_o.commit = out_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

  // Response valid flag: set on commit, cleared when the sink takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= opst_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/opst_dp.sv =====
module opst_dp #(
  parameter int unsigned MAX_ENTRIES = opst_pkg::DEFAULT_MAX_ENTRIES,
  localparam int unsigned CNT_W      = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  opst_pkg::ctrl_cmd_t             cmd_i,
  input  logic [opst_pkg::ACTION_W-1:0]   action_i,
  input  logic [opst_pkg::KEY_W-1:0]      first_key_i,
  input  logic [opst_pkg::KEY_W-1:0]      second_key_i,
  output logic                            is_present_o,
  output logic                            list_changed_o,
  output logic                            rejected_full_o,
  output logic [opst_pkg::OUT_CNT_W-1:0]  entry_count_o,
  output logic [CNT_W-1:0]                count_o
);

  localparam int unsigned PAIR_W = opst_pkg::PAIR_W;

  // Entry lanes, live count and the captured request.
  logic [PAIR_W-1:0]      store_q [MAX_ENTRIES];
  logic [PAIR_W-1:0]      store_d [MAX_ENTRIES];
  logic [CNT_W-1:0]       count_q, count_d;
  opst_pkg::action_e      action_q;
  logic [PAIR_W-1:0]      key_q;
  logic [MAX_ENTRIES-1:0] hit_d, hit_q;
  logic [MAX_ENTRIES-1:0] shift_d, shift_q;
  logic [PAIR_W-1:0]      key_in;

  // Response register.
  logic                           present_d, present_q;
  logic                           changed_d, changed_q;
  logic                           rejected_d, rejected_q;
  logic [opst_pkg::OUT_CNT_W-1:0] rsp_count_d, rsp_count_q;

  logic present, full, do_remove, do_append;

  assign key_in = {first_key_i, second_key_i};

  // Compare the incoming key against every live lane; a lane at or above the
  // hit position moves down by one if the entry is removed.
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_lane
    assign hit_d[j]   = (count_q > CNT_W'(j)) && (store_q[j] == key_in);
    assign shift_d[j] = |hit_d[j:0];
  end

  // Decide the list update from the captured hit vector.
  assign present = |hit_q;
  assign full    = (count_q == CNT_W'(MAX_ENTRIES));

  always_comb begin
    do_remove  = 1'b0;
    do_append  = 1'b0;
    present_d  = present;
    changed_d  = 1'b0;
    rejected_d = 1'b0;
    count_d    = count_q;
    unique case (action_q)
      opst_pkg::ACT_QUERY: begin
        present_d = present;
      end
      opst_pkg::ACT_TOGGLE: begin
        if (present) begin
          do_remove = 1'b1;
          present_d = 1'b0;
          changed_d = 1'b1;
        end else if (!full) begin
          do_append = 1'b1;
          present_d = 1'b1;
          changed_d = 1'b1;
        end else begin
          rejected_d = 1'b1;
        end
      end
      opst_pkg::ACT_ADD: begin
        if (!present) begin
          if (!full) begin
            do_append = 1'b1;
            present_d = 1'b1;
            changed_d = 1'b1;
          end else begin
            rejected_d = 1'b1;
          end
        end
      end
      opst_pkg::ACT_CLEAR: begin
        changed_d = (count_q != '0);
        present_d = 1'b0;
        count_d   = '0;
      end
      default: begin
        present_d = present;
      end
    endcase
    if (do_remove) count_d = count_q - CNT_W'(1);
    if (do_append) count_d = count_q + CNT_W'(1);
  end

  assign rsp_count_d = opst_pkg::OUT_CNT_W'(count_d);

  // Lane update: close the gap on removal, write the tail slot on append.
  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_upd
    if (j < MAX_ENTRIES - 1) begin : g_mid
      always_comb begin
        store_d[j] = store_q[j];
        if (do_remove && shift_q[j]) begin
          store_d[j] = store_q[j+1];
        end else if (do_append && (count_q == CNT_W'(j))) begin
          store_d[j] = key_q;
        end
      end
    end else begin : g_top
      always_comb begin
        store_d[j] = store_q[j];
        if (do_append && (count_q == CNT_W'(j))) begin
          store_d[j] = key_q;
        end
      end
    end
  end

  // Payload registers: lanes, captured request and response fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= opst_pkg::action_e'(action_i);
      key_q    <= key_in;
      hit_q    <= hit_d;
      shift_q  <= shift_d;
    end
    if (cmd_i.commit) begin
      store_q     <= store_d;
      present_q   <= present_d;
      changed_q   <= changed_d;
      rejected_q  <= rejected_d;
      rsp_count_q <= rsp_count_d;
    end
  end

  // Live count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.commit) begin
      count_q <= count_d;
    end
  end

  assign is_present_o    = present_q;
  assign list_changed_o  = changed_q;
  assign rejected_full_o = rejected_q;
  assign entry_count_o   = rsp_count_q;
  assign count_o         = count_q;

endmodule

// ===== dv/tb_ordered_pair_set_toggle.sv =====
`timescale 1ns / 1ps

module tb_ordered_pair_set_toggle;

  import opst_pkg::*;

  localparam int unsigned LIST_DEPTH  = DEFAULT_MAX_ENTRIES;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 10;
  localparam int unsigned PHASE_ITEMS = 270;

  typedef struct packed {
    action_e          action;
    logic [KEY_W-1:0] first_key;
    logic [KEY_W-1:0] second_key;
  } pair_request_t;

  typedef struct packed {
    logic                 is_present;
    logic                 list_changed;
    logic                 rejected_full;
    logic [OUT_CNT_W-1:0] entry_count;
  } pair_response_t;

  logic clk_i;
  logic rst_ni;

  opst_req_if req_if ();
  opst_rsp_if rsp_if ();

  ordered_pair_set_toggle dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predicted copy of the pair list.
  logic [PAIR_W-1:0] pair_list [LIST_DEPTH];
  int unsigned       list_len;

  pair_request_t  pending_requests [$];
  pair_response_t expected_results [$];

  // Small pools of key halves, so that random pairs hit the list often.
  logic [KEY_W-1:0] first_pool  [4];
  logic [KEY_W-1:0] second_pool [6];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;
  int unsigned cycle_count;
  logic        req_fire;

  // Clock with a 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Applies one request to the predicted list and returns the expected response.
  function automatic pair_response_t predict_list_step(pair_request_t req);
    logic [PAIR_W-1:0] key;
    int                hit;
    pair_response_t    rsp;
    key = {req.first_key, req.second_key};
    hit = -1;
    for (int i = 0; i < int'(list_len); i++) begin
      if (hit < 0 && pair_list[i] == key) begin
        hit = i;
      end
    end
    rsp.is_present    = (hit >= 0);
    rsp.list_changed  = 1'b0;
    rsp.rejected_full = 1'b0;
    case (req.action)
      ACT_TOGGLE: begin
        if (hit >= 0) begin
          // Close the gap so that insertion order is kept.
          for (int j = hit + 1; j < int'(list_len); j++) begin
            pair_list[j-1] = pair_list[j];
          end
          list_len--;
          rsp.is_present   = 1'b0;
          rsp.list_changed = 1'b1;
        end else if (list_len < LIST_DEPTH) begin
          pair_list[list_len] = key;
          list_len++;
          rsp.is_present   = 1'b1;
          rsp.list_changed = 1'b1;
        end else begin
          rsp.rejected_full = 1'b1;
        end
      end
      ACT_ADD: begin
        if (hit < 0) begin
          if (list_len < LIST_DEPTH) begin
            pair_list[list_len] = key;
            list_len++;
            rsp.is_present   = 1'b1;
            rsp.list_changed = 1'b1;
          end else begin
            rsp.rejected_full = 1'b1;
          end
        end
      end
      ACT_CLEAR: begin
        rsp.list_changed = (list_len != 0);
        rsp.is_present   = 1'b0;
        list_len         = 0;
      end
      default: begin
      end
    endcase
    rsp.entry_count = list_len[OUT_CNT_W-1:0];
    return rsp;
  endfunction

  task automatic queue_request(action_e act, logic [KEY_W-1:0] k1, logic [KEY_W-1:0] k2);
    pair_request_t req;
    req.action     = act;
    req.first_key  = k1;
    req.second_key = k2;
    pending_requests.push_back(req);
  endtask

  // Mostly pool keys with a realistic action mix; a tenth is pure noise.
  function automatic pair_request_t make_random_request();
    pair_request_t req;
    int unsigned   roll;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 10) begin
      req.action     = action_e'($urandom_range(3));
      req.first_key  = KEY_W'($urandom);
      req.second_key = KEY_W'($urandom);
    end else begin
      if (roll < 27) begin
        req.action = ACT_QUERY;
      end else if (roll < 62) begin
        req.action = ACT_TOGGLE;
      end else if (roll < 97) begin
        req.action = ACT_ADD;
      end else begin
        req.action = ACT_CLEAR;
      end
      req.first_key  = first_pool[$urandom_range(3)];
      req.second_key = second_pool[$urandom_range(5)];
    end
    return req;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Request driver and response back-pressure, both updated on the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      rsp_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_fire) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_request_t item;
          item = pending_requests.pop_front();
          req_if.valid      <= 1'b1;
          req_if.action     <= item.action;
          req_if.first_key  <= item.first_key;
          req_if.second_key <= item.second_key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts each accepted request and checks each accepted response.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        pair_request_t seen;
        seen.action     = action_e'(req_if.action);
        seen.first_key  = req_if.first_key;
        seen.second_key = req_if.second_key;
        expected_results.push_back(predict_list_step(seen));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("response with no request outstanding");
          error_count++;
        end else begin
          pair_response_t exp_rsp;
          exp_rsp = expected_results.pop_front();
          if (rsp_if.is_present !== exp_rsp.is_present) begin
            $error("is_present: expected %0d, actual %0d", exp_rsp.is_present,
                   rsp_if.is_present);
            error_count++;
          end
          if (rsp_if.list_changed !== exp_rsp.list_changed) begin
            $error("list_changed: expected %0d, actual %0d", exp_rsp.list_changed,
                   rsp_if.list_changed);
            error_count++;
          end
          if (rsp_if.rejected_full !== exp_rsp.rejected_full) begin
            $error("rejected_full: expected %0d, actual %0d", exp_rsp.rejected_full,
                   rsp_if.rejected_full);
            error_count++;
          end
          if (rsp_if.entry_count !== exp_rsp.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
                   rsp_if.entry_count);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** ordered_pair_set_toggle: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = ACT_QUERY;
    req_if.first_key  = '0;
    req_if.second_key = '0;
    rsp_if.ready      = 1'b0;
    send_idle_pct     = 17;
    recv_stall_pct    = 49;
    error_count       = 0;
    cycle_count       = 0;
    list_len          = 0;

    // Key pools include both extremes of each half.
    first_pool[0]  = '0;
    first_pool[1]  = '1;
    second_pool[0] = '0;
    second_pool[1] = '1;
    for (int i = 2; i < 4; i++) begin
      first_pool[i] = KEY_W'($urandom);
    end
    for (int i = 2; i < 6; i++) begin
      second_pool[i] = KEY_W'($urandom);
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty list, extreme keys, removal from the middle.
    queue_request(ACT_QUERY,  16'h0000, 16'h0000);
    queue_request(ACT_CLEAR,  16'h0000, 16'h0000);
    queue_request(ACT_TOGGLE, 16'h0000, 16'h0000);
    queue_request(ACT_TOGGLE, 16'hFFFF, 16'hFFFF);
    queue_request(ACT_TOGGLE, 16'h0000, 16'hFFFF);
    queue_request(ACT_TOGGLE, 16'hFFFF, 16'h0000);
    queue_request(ACT_QUERY,  16'hFFFF, 16'h0000);
    queue_request(ACT_ADD,    16'h0000, 16'hFFFF);
    queue_request(ACT_TOGGLE, 16'hFFFF, 16'hFFFF);
    // Fill the list up to capacity.
    for (int i = 1; i <= 13; i++) begin
      queue_request(ACT_ADD, KEY_W'(i), ~KEY_W'(i));
    end
    // Full list: absent inserts are refused, a present add is not.
    queue_request(ACT_ADD,    16'h1234, 16'h5678);
    queue_request(ACT_TOGGLE, 16'h1234, 16'h5678);
    queue_request(ACT_ADD,    16'h0000, 16'hFFFF);
    queue_request(ACT_TOGGLE, 16'h0005, ~16'h0005);
    queue_request(ACT_CLEAR,  16'h0000, 16'h0000);
    queue_request(ACT_QUERY,  16'h0000, 16'h0000);
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pending_requests.push_back(make_random_request());
    end
    wait_drained();

    // Slow sender, mostly ready receiver.
    send_idle_pct  = 49;
    recv_stall_pct = 17;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pending_requests.push_back(make_random_request());
    end
    wait_drained();

    // Back to back with no idling on either side.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      pending_requests.push_back(make_random_request());
    end
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** ordered_pair_set_toggle: PASSED **");
    end else begin
      $display("** ordered_pair_set_toggle: FAILED **");
    end
    $finish;
  end

endmodule
